// ===== rtl/b64d_pkg.sv =====
// Package for the base64 stream decoder: result item type, constants,
// configuration register indexes and the character and byte mapping functions.
// Used by base64_lsb_first_stream_decoder; depends on nothing else.
`default_nettype none

package b64d_pkg;

  // Configuration register indexes.
  localparam logic CFG_ALPHABET_SELECT     = 1'b0;
  localparam logic CFG_ALLOW_CONTROL_BYTES = 1'b1;

  localparam logic [6:0] PAD_VALUE    = 7'd64;
  localparam logic [7:0] CTRL_LIMIT   = 8'd31;
  localparam logic [7:0] CTRL_REPLACE = 8'd95;  // '_'

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_RETURN  = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;

  // Up to three data bytes and one terminator per character.
  localparam int unsigned MAX_RES = 4;

  typedef struct packed {
    logic [7:0] data;
    logic       term;
    logic       partial;
  } b64d_res_t;

  function automatic logic is_space(input logic [7:0] ch);
    return (ch == CH_NEWLINE) || (ch == CH_RETURN) || (ch == CH_SPACE) || (ch == CH_TAB);
  endfunction

  // Maps one character to 0..63, the pad to 64, anything unknown to 0.
  function automatic logic [6:0] map_char(input logic [7:0] ch, input logic path);
    logic [6:0] v;
    v = 7'd0;
    if (ch >= "A" && ch <= "Z") begin
      v = 7'(ch - 8'h41);
    end else if (ch >= "a" && ch <= "z") begin
      v = 7'(ch - 8'h61 + 8'd26);
    end else if (ch >= "0" && ch <= "9") begin
      v = 7'(ch - 8'h30 + 8'd52);
    end else if (path) begin
      if (ch == "_") v = 7'd62;
      else if (ch == ".") v = 7'd63;
      else if (ch == "-") v = PAD_VALUE;
    end else begin
      if (ch == "+") v = 7'd62;
      else if (ch == "/") v = 7'd63;
      else if (ch == "=") v = PAD_VALUE;
    end
    return v;
  endfunction

  // Builds a data byte result, replacing control bytes in path mode.
  function automatic b64d_res_t data_res(input logic [7:0] b, input logic path,
                                         input logic allow_ctrl);
    b64d_res_t r;
    r.data    = (path && !allow_ctrl && b <= CTRL_LIMIT) ? CTRL_REPLACE : b;
    r.term    = 1'b0;
    r.partial = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/base64_lsb_first_stream_decoder.sv =====
// Top level of the base64 stream decoder: input register, group decode and a
// result batch register, drained one per cycle unless stalled. Depends on b64d_pkg.
`default_nettype none

// Decodes base64 text one character per request, least significant value
// first, with a standard or path-safe alphabet chosen by register 0. Every
// character is decoded in an input register; its up to four results (three
// bytes and a terminator) load a four-entry batch register. While the output
// does not stall, the batch presents one result per cycle and, as characters
// that cause no result pass through while a batch drains, the block takes
// one character per cycle in steady state; a character that causes results
// waits until the batch is empty or its last result is taken. The
// configuration port is always ready and must be written only while idle.
module base64_lsb_first_stream_decoder
  import b64d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  // Character channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char_in,
  input  wire logic       in_end_of_text,
  // Result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte_out,
  output logic            out_is_terminator,
  output logic            out_partial_dropped,
  // Configuration channel
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_index,
  input  wire logic       cfg_data
);

  // Configuration
  logic alpha_sel_r, allow_ctrl_r;

  // Input register
  logic       s1_vld_r, s1_vld_nxt;
  logic [7:0] s1_char_r;
  logic       s1_eot_r;

  // Group state
  logic [6:0] gv_r   [3];
  logic [6:0] gv_nxt [3];
  logic [1:0] pos_r, pos_nxt;

  // Result batch
  b64d_res_t  ent_r   [MAX_RES];
  b64d_res_t  ent_nxt [MAX_RES];
  logic [1:0] rd_r, rd_nxt;
  logic [2:0] rem_r, rem_nxt;

  logic       in_acc, out_acc, s1_adv, batch_free;
  logic [2:0] k;
  logic [6:0] v;
  logic [24:0] n;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (rem_r != 3'd0);
  assign out_acc   = out_valid && !out_stall;

  assign out_byte_out        = ent_r[rd_r].data;
  assign out_is_terminator   = ent_r[rd_r].term;
  assign out_partial_dropped = ent_r[rd_r].partial;

  // The batch can be reloaded once it is empty or its last result leaves now.
  assign batch_free = (rem_r == 3'd0) || ((rem_r == 3'd1) && out_acc);
  assign s1_adv     = s1_vld_r && ((k == 3'd0) || batch_free);
  assign in_stall   = s1_vld_r && !s1_adv;
  assign s1_vld_nxt = in_acc || (s1_vld_r && !s1_adv);

  // Decode of the character in the input register.
  always_comb begin
    v       = map_char(s1_char_r, alpha_sel_r);
    n       = {18'd0, gv_r[0]} | {12'd0, gv_r[1], 6'd0} | {6'd0, gv_r[2], 12'd0} |
              {v, 18'd0};
    gv_nxt  = gv_r;
    pos_nxt = pos_r;
    k       = 3'd0;
    for (int i = 0; i < MAX_RES; i++) begin
      ent_nxt[i] = '0;
    end
    if (!is_space(s1_char_r)) begin
      if (pos_r != 2'd3) begin
        gv_nxt[pos_r] = v;
        pos_nxt       = pos_r + 2'd1;
      end else begin
        ent_nxt[0] = data_res(n[7:0], alpha_sel_r, allow_ctrl_r);
        k          = 3'd1;
        if (gv_r[2] != PAD_VALUE) begin
          ent_nxt[1] = data_res(n[15:8], alpha_sel_r, allow_ctrl_r);
          k          = 3'd2;
          if (v != PAD_VALUE) begin
            ent_nxt[2] = data_res(n[23:16], alpha_sel_r, allow_ctrl_r);
            k          = 3'd3;
          end
        end
        pos_nxt = 2'd0;
      end
    end
    if (s1_eot_r) begin
      ent_nxt[k[1:0]].data    = 8'd0;
      ent_nxt[k[1:0]].term    = 1'b1;
      ent_nxt[k[1:0]].partial = (pos_nxt != 2'd0);
      k       = k + 3'd1;
      pos_nxt = 2'd0;
    end
  end

  always_comb begin
    rd_nxt  = rd_r;
    rem_nxt = rem_r;
    if (out_acc) begin
      rd_nxt  = rd_r + 2'd1;
      rem_nxt = rem_r - 3'd1;
    end
    if (s1_adv && (k != 3'd0)) begin
      rd_nxt  = 2'd0;
      rem_nxt = k;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_sel_r  <= 1'b0;
      allow_ctrl_r <= 1'b0;
      s1_vld_r     <= 1'b0;
      pos_r        <= 2'd0;
      rd_r         <= 2'd0;
      rem_r        <= 3'd0;
      for (int i = 0; i < 3; i++) begin
        gv_r[i] <= 7'd0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_ALPHABET_SELECT:     alpha_sel_r  <= cfg_data;
          CFG_ALLOW_CONTROL_BYTES: allow_ctrl_r <= cfg_data;
          default: ;
        endcase
      end
      s1_vld_r <= s1_vld_nxt;
      rd_r     <= rd_nxt;
      rem_r    <= rem_nxt;
      if (s1_adv) begin
        pos_r <= pos_nxt;
        gv_r  <= gv_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_char_r <= in_char_in;
      s1_eot_r  <= in_end_of_text;
    end
    if (s1_adv && (k != 3'd0)) begin
      ent_r <= ent_nxt;
    end
  end

`ifndef SYNTH
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, rd_r} + {1'b0, rem_r}) <= 4'd4)
    else $error("result batch pointer runs past the batch");

  a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_terminator) |-> (rem_r == 3'd1))
    else $error("terminator is not the last result of its batch");

  a_partial_term: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_partial_dropped) |-> out_is_terminator)
    else $error("partial flag on a data byte");

  a_term_resets_group: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_eot_r) |=> (pos_r == 2'd0))
    else $error("group position not cleared after end of text");
`endif

endmodule

`default_nettype wire
